// ===== hw/rtl/sdq_pkg.sv =====
package sdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_SEARCH     = 3'd4;
  localparam logic [2:0] ACT_DELETE     = 3'd5;
  localparam logic [2:0] ACT_SWAP       = 3'd6;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] second_key;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic signed [KEY_W-1:0] popped_key;
    logic [4:0]              entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_KEY,
    CMD_SECOND_KEY,
    CMD_FROM_LEFT,
    CMD_FROM_RIGHT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      cmp_en;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/sdq_cell.sv =====
module sdq_cell
  import sdq_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [KEY_W-1:0] second_key,
  input  logic signed [KEY_W-1:0] left_data,
  input  logic signed [KEY_W-1:0] right_data,
  output logic signed [KEY_W-1:0] data,
  output logic                    match_key,
  output logic                    match_second
);

  logic signed [KEY_W-1:0] data_r;
  logic signed [KEY_W-1:0] data_nxt;
  logic                    match_key_r;
  logic                    match_second_r;

  always_comb begin
    unique case (ctl.cmd)
      CMD_KEY:        data_nxt = key;
      CMD_SECOND_KEY: data_nxt = second_key;
      CMD_FROM_LEFT:  data_nxt = left_data;
      CMD_FROM_RIGHT: data_nxt = right_data;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.cmp_en) begin
      match_key_r    <= (data_r == key);
      match_second_r <= (data_r == second_key);
    end
  end

  assign data         = data_r;
  assign match_key    = match_key_r;
  assign match_second = match_second_r;

endmodule

// ===== hw/rtl/searchable_deque.sv =====
// Double-ended queue of up to DEPTH signed 32-bit keys held in a row of cells, one key per
// cell, with position 0 at the front. Every item gives exactly one result. An item is
// accepted, then every cell compares its key against both search keys at once, then the
// first matches are picked and the whole row shifts, loads or swaps in a single step,
// which waits while the previous result is unread. A new item is accepted only after the
// previous one is applied, even while its result still waits in the output register.
// Stored keys need no clearing after reset; only state, count and out_valid are reset.
module searchable_deque
  import sdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  in_item_t                item_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  cell_ctl_t               ctl     [DEPTH];
  logic signed [KEY_W-1:0] cdata   [DEPTH];
  logic [DEPTH-1:0]        m_key, m_second, valid_vec;
  logic [DEPTH-1:0]        first_key, first_second, from_first;
  logic                    found_key, found_second;
  logic                    apply_fire, in_fire;
  logic                    not_full, not_empty;
  logic                    ok;
  logic signed [KEY_W-1:0] popped;
  logic [IDX_W-1:0]        back_idx;

  assign in_ready   = rst_n && (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign apply_fire = (state_r == ST_APPLY) && (!out_valid_r || out_ready);
  assign not_full   = (count_r < CNT_W'(DEPTH));
  assign not_empty  = (count_r != '0);
  assign back_idx   = IDX_W'(count_r - 1'b1);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = (CNT_W'(i) < count_r);
    end
  end

  assign first_key    = (m_key & valid_vec) & (~(m_key & valid_vec) + 1'b1);
  assign first_second = (m_second & valid_vec) & (~(m_second & valid_vec) + 1'b1);
  assign found_key    = |(m_key & valid_vec);
  assign found_second = |(m_second & valid_vec);
  assign from_first   = ~(first_key - 1'b1);

  always_comb begin
    ok        = 1'b0;
    popped    = '0;
    count_nxt = count_r;
    unique case (item_r.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        ok = not_full;
        if (not_full) count_nxt = count_r + 1'b1;
      end
      ACT_POP_FRONT: begin
        ok = not_empty;
        if (not_empty) begin
          popped    = cdata[0];
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        ok = not_empty;
        if (not_empty) begin
          popped    = cdata[back_idx];
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_SEARCH: ok = found_key;
      ACT_DELETE: begin
        ok = found_key;
        if (found_key) count_nxt = count_r - 1'b1;
      end
      ACT_SWAP: ok = found_key && found_second;
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].cmp_en = (state_r == ST_MATCH);
      ctl[i].cmd    = CMD_HOLD;
      if (apply_fire) begin
        unique case (item_r.action)
          ACT_PUSH_FRONT: begin
            if (not_full) ctl[i].cmd = (i == 0) ? CMD_KEY : CMD_FROM_LEFT;
          end
          ACT_PUSH_BACK: begin
            if (not_full && (CNT_W'(i) == count_r)) ctl[i].cmd = CMD_KEY;
          end
          ACT_POP_FRONT: begin
            if (not_empty) ctl[i].cmd = CMD_FROM_RIGHT;
          end
          ACT_DELETE: begin
            if (found_key && from_first[i]) ctl[i].cmd = CMD_FROM_RIGHT;
          end
          ACT_SWAP: begin
            if (found_key && found_second) begin
              if (first_key[i]) ctl[i].cmd = CMD_SECOND_KEY;
              else if (first_second[i]) ctl[i].cmd = CMD_KEY;
            end
          end
          default: ctl[i].cmd = CMD_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [KEY_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = cdata[g];
    end else begin : g_mid
      assign left_d = cdata[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = cdata[g];
    end else begin : g_inner
      assign right_d = cdata[g+1];
    end
    sdq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl[g]),
      .key          (item_r.key),
      .second_key   (item_r.second_key),
      .left_data    (left_d),
      .right_data   (right_d),
      .data         (cdata[g]),
      .match_key    (m_key[g]),
      .match_second (m_second[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_APPLY;
      ST_APPLY: if (apply_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_item;
    if (apply_fire) begin
      out_item_r.ok          <= ok;
      out_item_r.popped_key  <= popped;
      out_item_r.entry_count <= 5'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_MATCH)
    else $error("accepted item did not enter the compare cycle");

  a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    apply_fire |=> out_valid_r && state_r == ST_IDLE)
    else $error("update cycle did not load a result");

  a_count_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
    !apply_fire |=> $stable(count_r))
    else $error("count changed outside the update cycle");

endmodule
